@@ rtl/iorpq_pkg.sv @@
// iorpq_pkg: shared types and codes of the i/o request priority queue
`default_nettype none
package iorpq_pkg;

	localparam logic [1:0] MODE_ENQ    = 2'd0;
	localparam logic [1:0] MODE_CANCEL = 2'd1;
	localparam logic [1:0] MODE_DISP   = 2'd2;
	localparam logic [1:0] MODE_UNUSED = 2'd3;

	localparam logic [2:0] ST_ACCEPTED   = 3'd0;
	localparam logic [2:0] ST_FULL       = 3'd1;
	localparam logic [2:0] ST_CANCELED   = 3'd2;
	localparam logic [2:0] ST_DISPATCHED = 3'd3;
	localparam logic [2:0] ST_EMPTY      = 3'd4;

	localparam logic [2:0] ADDR_LIMIT = 3'd0;

	localparam logic [7:0] LIMIT_RESET = 8'd101;

	typedef struct packed {
		logic [15:0]        handle;
		logic signed [7:0]  priority_req;
		logic               is_write;
		logic [31:0]        byte_count;
		logic [47:0]        file_offset;
		logic [47:0]        buffer_address;
		logic [7:0]         reply_tag;
	} entry_t;

	typedef struct packed {
		logic [1:0]         mode;
		logic [15:0]        handle;
		logic signed [7:0]  priority_req;
		logic               is_write;
		logic [31:0]        byte_count;
		logic [47:0]        file_offset;
		logic [47:0]        buffer_address;
		logic [7:0]         reply_tag;
	} req_t;

	typedef struct packed {
		logic [2:0]         status;
		logic [15:0]        out_handle;
		logic signed [7:0]  out_priority;
		logic               out_is_write;
		logic [31:0]        out_byte_count;
		logic [47:0]        out_file_offset;
		logic [47:0]        out_buffer_address;
		logic [7:0]         out_reply_tag;
		logic [7:0]         removed_count;
		logic               last;
	} res_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_NEW,
		CELL_LEFT,
		CELL_RIGHT
	} cell_op_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_CANCEL,
		S_DISP
	} state_t;

endpackage
`default_nettype wire

@@ rtl/io_request_priority_queue.sv @@
// io_request_priority_queue: top level, cell chain with command sequencer
//
//  channel   ports                               handshake
//  request   start, busy, req                    start && !busy
//  result    done, res                           done, one cycle, no stall
//  config    psel penable pwrite paddr pwdata    apb, pready tied high
//
// enqueue: result on the next cycle; block stays free
// cancel: the chain rotates each queued entry through the head
// dispatch: pops up to BATCH entries, results back to back
// reset clears count and sequencer, sets the limit; slot contents stay undefined
// busy is high while cancel or dispatch runs; results cannot be stalled
`default_nettype none
module io_request_priority_queue #(
	parameter int DEPTH = 128,
	parameter int BATCH = 5
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire iorpq_pkg::req_t   req,
	output logic                   done,
	output iorpq_pkg::res_t        res,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [2:0]        paddr,
	input  wire logic [31:0]       pwdata,
	output logic [31:0]            prdata,
	output logic                   pready
);
	localparam int CW   = $clog2(DEPTH + 1);
	localparam int BW   = $clog2(BATCH + 1);
	localparam int CMPW = (CW > 8) ? CW : 8;

	iorpq_pkg::state_t state_q, state_d;
	logic [CW-1:0] count_q, len_q, steps_q;
	logic [BW-1:0] k_q;
	logic [15:0]   hnd_q;
	logic [7:0]    rem_q;
	logic [7:0]    limit_q;
	logic          done_q;
	iorpq_pkg::res_t res_q, res_d;

	iorpq_pkg::entry_t   cell_data [DEPTH];
	wire logic [DEPTH-1:0] higher, ge;
	iorpq_pkg::entry_t   bus;
	iorpq_pkg::entry_t   new_entry;

	logic accept, full, keep, disp_last;

	assign pready = 1'b1;
	assign prdata = (paddr == iorpq_pkg::ADDR_LIMIT) ? {24'd0, limit_q} : 32'd0;
	assign busy   = state_q != iorpq_pkg::S_IDLE;
	assign accept = start && !busy;
	assign done   = done_q;
	assign res    = res_q;

	assign new_entry = '{handle: req.handle, priority_req: req.priority_req,
		is_write: req.is_write, byte_count: req.byte_count,
		file_offset: req.file_offset, buffer_address: req.buffer_address,
		reply_tag: req.reply_tag};

	assign full = (CMPW'(count_q) >= CMPW'(limit_q)) || (CMPW'(count_q) >= CMPW'(DEPTH));
	assign keep = cell_data[0].handle != hnd_q;
	assign disp_last = (count_q == CW'(1)) || (k_q == BW'(BATCH - 1));
	assign bus = (state_q == iorpq_pkg::S_CANCEL) ? cell_data[0] : new_entry;

	// slots 1.. stay sorted, so the insertion point is where ge first rises
	genvar gi;
	generate
		for (gi = 0; gi < DEPTH; gi++) begin : g_cell
			iorpq_pkg::cell_op_t cell_op;

			if (gi == 0) begin : g_head
				assign ge[gi] = count_q == '0;
			end else begin : g_body
				assign ge[gi] = (CW'(gi) >= count_q) || higher[gi];
			end

			always_comb begin
				cell_op = iorpq_pkg::CELL_HOLD;
				priority if (state_q == iorpq_pkg::S_IDLE) begin
					if (accept && req.mode == iorpq_pkg::MODE_ENQ && !full) begin
						if (gi > 0 && ge[(gi > 0) ? gi - 1 : 0])
							cell_op = iorpq_pkg::CELL_LEFT;
						else if (ge[gi])
							cell_op = iorpq_pkg::CELL_NEW;
					end
				end else if (state_q == iorpq_pkg::S_CANCEL) begin
					// rotate: head leaves, kept head goes back in at the tail
					if (keep && CW'(gi) == len_q - CW'(1))
						cell_op = iorpq_pkg::CELL_NEW;
					else
						cell_op = iorpq_pkg::CELL_RIGHT;
				end else begin
					cell_op = iorpq_pkg::CELL_RIGHT;
				end
			end

			iorpq_cell u_cell (
				.clk        (clk),
				.op         (cell_op),
				.bus        (bus),
				.prev       (cell_data[(gi > 0) ? gi - 1 : 0]),
				.next       (cell_data[(gi < DEPTH - 1) ? gi + 1 : gi]),
				.data       (cell_data[gi]),
				.bus_higher (higher[gi])
			);
		end
	endgenerate

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			iorpq_pkg::S_IDLE: begin
				if (accept && req.mode == iorpq_pkg::MODE_CANCEL && count_q != '0)
					state_d = iorpq_pkg::S_CANCEL;
				else if (accept && req.mode == iorpq_pkg::MODE_DISP && count_q != '0)
					state_d = iorpq_pkg::S_DISP;
			end
			iorpq_pkg::S_CANCEL: begin
				if (steps_q == CW'(1))
					state_d = iorpq_pkg::S_IDLE;
			end
			iorpq_pkg::S_DISP: begin
				if (disp_last)
					state_d = iorpq_pkg::S_IDLE;
			end
			default: state_d = iorpq_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= iorpq_pkg::S_IDLE;
			count_q <= '0;
			len_q   <= '0;
			steps_q <= '0;
			k_q     <= '0;
			rem_q   <= '0;
			done_q  <= 1'b0;
			limit_q <= iorpq_pkg::LIMIT_RESET;
		end else begin
			state_q <= state_d;
			if (psel && penable && pwrite && paddr == iorpq_pkg::ADDR_LIMIT)
				limit_q <= pwdata[7:0];
			unique case (state_q)
				iorpq_pkg::S_IDLE: begin
					len_q   <= count_q;
					steps_q <= count_q;
					k_q     <= '0;
					rem_q   <= '0;
					done_q  <= accept && (req.mode != iorpq_pkg::MODE_UNUSED) &&
						!(req.mode == iorpq_pkg::MODE_CANCEL && count_q != '0) &&
						!(req.mode == iorpq_pkg::MODE_DISP && count_q != '0);
					if (accept && req.mode == iorpq_pkg::MODE_ENQ && !full)
						count_q <= count_q + CW'(1);
				end
				iorpq_pkg::S_CANCEL: begin
					steps_q <= steps_q - CW'(1);
					done_q  <= steps_q == CW'(1);
					if (!keep) begin
						len_q <= len_q - CW'(1);
						if (rem_q != 8'hff)
							rem_q <= rem_q + 8'd1;
					end
					if (steps_q == CW'(1))
						count_q <= keep ? len_q : len_q - CW'(1);
				end
				iorpq_pkg::S_DISP: begin
					done_q  <= 1'b1;
					k_q     <= k_q + BW'(1);
					count_q <= count_q - CW'(1);
				end
				default: done_q <= 1'b0;
			endcase
		end
	end

	always_comb begin
		res_d      = '0;
		res_d.last = 1'b1;
		unique case (state_q)
			iorpq_pkg::S_IDLE: begin
				if (req.mode == iorpq_pkg::MODE_ENQ)
					res_d.status = full ? iorpq_pkg::ST_FULL : iorpq_pkg::ST_ACCEPTED;
				else if (req.mode == iorpq_pkg::MODE_CANCEL)
					res_d.status = iorpq_pkg::ST_CANCELED;
				else
					res_d.status = iorpq_pkg::ST_EMPTY;
			end
			iorpq_pkg::S_CANCEL: begin
				res_d.status        = iorpq_pkg::ST_CANCELED;
				res_d.removed_count = (!keep && rem_q != 8'hff) ? rem_q + 8'd1 : rem_q;
			end
			iorpq_pkg::S_DISP: begin
				res_d.status             = iorpq_pkg::ST_DISPATCHED;
				res_d.out_handle         = cell_data[0].handle;
				res_d.out_priority       = cell_data[0].priority_req;
				res_d.out_is_write       = cell_data[0].is_write;
				res_d.out_byte_count     = cell_data[0].byte_count;
				res_d.out_file_offset    = cell_data[0].file_offset;
				res_d.out_buffer_address = cell_data[0].buffer_address;
				res_d.out_reply_tag      = cell_data[0].reply_tag;
				res_d.last               = disp_last;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		res_q <= res_d;
		if (state_q == iorpq_pkg::S_IDLE)
			hnd_q <= req.handle;
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		CMPW'(count_q) <= CMPW'(DEPTH))
		else $error("queued count beyond depth");
	a_enq_done: assert property (@(posedge clk) disable iff (!arst_n)
		accept && req.mode == iorpq_pkg::MODE_ENQ |=> done && res.last)
		else $error("enqueue gave no single result");
	a_full_hold: assert property (@(posedge clk) disable iff (!arst_n)
		accept && req.mode == iorpq_pkg::MODE_ENQ && full |=> $stable(count_q))
		else $error("refused request changed count");
	a_disp_status: assert property (@(posedge clk) disable iff (!arst_n)
		$past(state_q) == iorpq_pkg::S_DISP && done |->
			res.status == iorpq_pkg::ST_DISPATCHED)
		else $error("dispatch result with wrong status");
`endif
endmodule
`default_nettype wire

@@ rtl/iorpq_cell.sv @@
// iorpq_cell: one queue slot, loads from its neighbors or the shared bus
`default_nettype none
module iorpq_cell (
	input  wire logic               clk,
	input  wire iorpq_pkg::cell_op_t op,
	input  wire iorpq_pkg::entry_t  bus,
	input  wire iorpq_pkg::entry_t  prev,
	input  wire iorpq_pkg::entry_t  next,
	output iorpq_pkg::entry_t       data,
	output logic                    bus_higher
);
	iorpq_pkg::entry_t data_q;

	assign data = data_q;
	// new request outranks this slot
	assign bus_higher = bus.priority_req > data_q.priority_req;

	always_ff @(posedge clk) begin
		unique case (op)
			iorpq_pkg::CELL_NEW:   data_q <= bus;
			iorpq_pkg::CELL_LEFT:  data_q <= prev;
			iorpq_pkg::CELL_RIGHT: data_q <= next;
			default:               data_q <= data_q;
		endcase
	end
endmodule
`default_nettype wire
